// ===== hdl/compass_heading_from_field_top_assert.svh =====
// Assertion macros shared by the heading pipeline modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef COMPASS_HEADING_FROM_FIELD_TOP_ASSERT_SVH
`define COMPASS_HEADING_FROM_FIELD_TOP_ASSERT_SVH

// Same-cycle implication.
`define CHF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/chf_pkg.sv =====
package chf_pkg;

    localparam int RAW_W            = 25;
    localparam int FLD_W            = RAW_W + 1;
    localparam int CFG_W            = 25;
    localparam int CFG_IDX_W        = 2;
    localparam int DEG_W            = 9;
    localparam int PRESCALE         = 30;
    localparam int CW               = FLD_W + PRESCALE + 2;
    localparam int ZFRAC            = 16;
    localparam int ZW               = 26;
    localparam int ZT_W             = ZW - ZFRAC;
    localparam int SUM_W            = ZT_W + 1;
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int ATAN_IDX_W       = 5;

    localparam logic signed [ZW-1:0]    Z_180   = ZW'(180 * 65536);
    localparam logic signed [DEG_W-1:0] DEG_0   = DEG_W'(0);
    localparam logic signed [DEG_W-1:0] DEG_45  = DEG_W'(45);
    localparam logic signed [DEG_W-1:0] DEG_90  = DEG_W'(90);
    localparam logic signed [DEG_W-1:0] DEG_135 = DEG_W'(135);
    localparam logic signed [DEG_W-1:0] DEG_180 = DEG_W'(180);
    localparam logic signed [SUM_W-1:0] SUM_360 = SUM_W'(360);
    localparam logic signed [SUM_W-1:0] SUM_N360 = -SUM_W'(360);
    localparam logic signed [SUM_W-1:0] SUM_720 = SUM_W'(720);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X = 2'd0,
        CFG_OFFSET_Y = 2'd1,
        CFG_OFFSET_Z = 2'd2,
        CFG_DECL     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [FLD_W-1:0] fx;
        logic signed [FLD_W-1:0] fy;
        logic signed [FLD_W-1:0] fz;
        logic                    ok;
    } t_fld;

    typedef struct packed {
        t_fld                    fld;
        logic                    bypass;
        logic signed [DEG_W-1:0] byp_deg;
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ZW-1:0]    z;
    } t_cord;

    // atan(2^-k) in degrees, Q16, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] k);
        logic signed [ZW-1:0] v;
        case (k)
            5'd0:    v = ZW'(2949120);
            5'd1:    v = ZW'(1740967);
            5'd2:    v = ZW'(919879);
            5'd3:    v = ZW'(466945);
            5'd4:    v = ZW'(234379);
            5'd5:    v = ZW'(117304);
            5'd6:    v = ZW'(58666);
            5'd7:    v = ZW'(29335);
            5'd8:    v = ZW'(14668);
            5'd9:    v = ZW'(7334);
            5'd10:   v = ZW'(3667);
            5'd11:   v = ZW'(1833);
            5'd12:   v = ZW'(917);
            5'd13:   v = ZW'(458);
            5'd14:   v = ZW'(229);
            5'd15:   v = ZW'(115);
            5'd16:   v = ZW'(57);
            5'd17:   v = ZW'(29);
            5'd18:   v = ZW'(14);
            5'd19:   v = ZW'(7);
            5'd20:   v = ZW'(4);
            5'd21:   v = ZW'(2);
            5'd22:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/chf_in_if.sv =====
interface chf_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [chf_pkg::RAW_W-1:0] raw_x;
    logic signed [chf_pkg::RAW_W-1:0] raw_y;
    logic signed [chf_pkg::RAW_W-1:0] raw_z;
    logic                             sample_valid;

    modport source (output valid, raw_x, raw_y, raw_z, sample_valid, input ready);
    modport sink   (input valid, raw_x, raw_y, raw_z, sample_valid, output ready);
endinterface

// ===== hdl/chf_out_if.sv =====
interface chf_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [chf_pkg::FLD_W-1:0] field_x;
    logic signed [chf_pkg::FLD_W-1:0] field_y;
    logic signed [chf_pkg::FLD_W-1:0] field_z;
    logic        [chf_pkg::DEG_W-1:0] heading_deg;
    logic                             ok;

    modport source (output valid, field_x, field_y, field_z, heading_deg, ok, input ready);
    modport sink   (input valid, field_x, field_y, field_z, heading_deg, ok, output ready);
endinterface

// ===== hdl/compass_heading_from_field_top.sv =====
// Magnetometer compass: offset correction and atan2 heading.
// Input channel i_in carries one raw x, y, z reading and a sample_valid flag
// per beat; output channel o_out carries the corrected field, the heading in
// whole degrees (0 to 360) and ok. Both use valid/ready; a beat moves when
// both are high. Offsets and declination are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write them only while no beat is
// in flight, since the block itself does not enforce this. The path is an
// offset adder stage, a classify and pre-rotation stage, one register stage
// per CORDIC rotation and an output stage. One beat is accepted every cycle
// while i_in.ready is high; every stage has its own valid bit.
// When the receiver stalls, the output register holds its beat and each stage
// keeps accepting until it is full, so empty slots close up before i_in.ready
// drops. Reset clears all valid bits and sets the offsets and the declination
// to zero; no beat is lost or repeated across a stall.
module compass_heading_from_field_top #(
    parameter int CORDIC_STEPS = chf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [chf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [chf_pkg::CFG_W-1:0]          i_cfg_data,
    chf_in_if.sink                             i_in,
    chf_out_if.source                          o_out
);

    logic signed [chf_pkg::CFG_W-1:0] r_off_x;
    logic signed [chf_pkg::CFG_W-1:0] r_off_y;
    logic signed [chf_pkg::CFG_W-1:0] r_off_z;
    logic signed [chf_pkg::DEG_W-1:0] r_decl;

    chf_pkg::t_cord w_beat  [0:CORDIC_STEPS];
    logic           w_valid [0:CORDIC_STEPS];
    logic           w_ready [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
            r_decl  <= '0;
        end else if (i_cfg_we) begin
            unique case (chf_pkg::t_cfg_idx'(i_cfg_idx))
                chf_pkg::CFG_OFFSET_X: r_off_x <= i_cfg_data;
                chf_pkg::CFG_OFFSET_Y: r_off_y <= i_cfg_data;
                chf_pkg::CFG_OFFSET_Z: r_off_z <= i_cfg_data;
                chf_pkg::CFG_DECL:     r_decl  <= i_cfg_data[chf_pkg::DEG_W-1:0];
            endcase
        end
    end

    chf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_off_x (r_off_x),
        .i_off_y (r_off_y),
        .i_off_z (r_off_z),
        .o_beat  (w_beat[0]),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
        chf_stage #(
            .STEP (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_beat[g]),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .o_beat  (w_beat[g+1]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1])
        );
    end

    chf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_beat[CORDIC_STEPS]),
        .i_valid (w_valid[CORDIC_STEPS]),
        .o_ready (w_ready[CORDIC_STEPS]),
        .i_decl  (r_decl),
        .o_out   (o_out)
    );

endmodule

// ===== hdl/chf_front.sv =====
`include "compass_heading_from_field_top_assert.svh"

module chf_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    chf_in_if.sink                              i_in,
    input  logic signed [chf_pkg::CFG_W-1:0]    i_off_x,
    input  logic signed [chf_pkg::CFG_W-1:0]    i_off_y,
    input  logic signed [chf_pkg::CFG_W-1:0]    i_off_z,
    output chf_pkg::t_cord                      o_beat,
    output logic                                o_valid,
    input  logic                                i_ready
);

    localparam int FW = chf_pkg::FLD_W;
    localparam int CW = chf_pkg::CW;

    logic              r_a_valid;
    chf_pkg::t_fld     r_a_fld;
    chf_pkg::t_fld     n_a_fld;
    logic              r_b_valid;
    chf_pkg::t_cord    r_b_beat;
    chf_pkg::t_cord    n_b_beat;
    logic              en_a;
    logic              en_b;
    logic [FW:0]       ax;
    logic [FW:0]       ay;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign en_b       = !r_b_valid || i_ready;
    assign en_a       = !r_a_valid || en_b;
    assign i_in.ready = en_a;

    always_comb begin
        n_a_fld.fx = {i_in.raw_x[chf_pkg::RAW_W-1], i_in.raw_x}
                   + {i_off_x[chf_pkg::CFG_W-1], i_off_x};
        n_a_fld.fy = {i_in.raw_y[chf_pkg::RAW_W-1], i_in.raw_y}
                   + {i_off_y[chf_pkg::CFG_W-1], i_off_y};
        n_a_fld.fz = {i_in.raw_z[chf_pkg::RAW_W-1], i_in.raw_z}
                   + {i_off_z[chf_pkg::CFG_W-1], i_off_z};
        n_a_fld.ok = i_in.sample_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_in.valid) begin
            r_a_fld <= n_a_fld;
        end
    end

    always_comb begin
        ax = r_a_fld.fx[FW-1] ? -{r_a_fld.fx[FW-1], r_a_fld.fx} : {r_a_fld.fx[FW-1], r_a_fld.fx};
        ay = r_a_fld.fy[FW-1] ? -{r_a_fld.fy[FW-1], r_a_fld.fy} : {r_a_fld.fy[FW-1], r_a_fld.fy};
        xs = {{(CW-FW){r_a_fld.fx[FW-1]}}, r_a_fld.fx} <<< chf_pkg::PRESCALE;
        ys = {{(CW-FW){r_a_fld.fy[FW-1]}}, r_a_fld.fy} <<< chf_pkg::PRESCALE;

        n_b_beat.fld    = r_a_fld;
        n_b_beat.bypass = (r_a_fld.fy == '0) || (r_a_fld.fx == '0) || (ax == ay);
        if (r_a_fld.fy == '0) begin
            n_b_beat.byp_deg = r_a_fld.fx[FW-1] ? chf_pkg::DEG_180 : chf_pkg::DEG_0;
        end else if (r_a_fld.fx == '0) begin
            n_b_beat.byp_deg = r_a_fld.fy[FW-1] ? -chf_pkg::DEG_90 : chf_pkg::DEG_90;
        end else if (!r_a_fld.fx[FW-1]) begin
            n_b_beat.byp_deg = r_a_fld.fy[FW-1] ? -chf_pkg::DEG_45 : chf_pkg::DEG_45;
        end else begin
            n_b_beat.byp_deg = r_a_fld.fy[FW-1] ? -chf_pkg::DEG_135 : chf_pkg::DEG_135;
        end

        // The left half plane is turned by 180 degrees before the rotations.
        if (r_a_fld.fx[FW-1]) begin
            n_b_beat.x = -xs;
            n_b_beat.y = -ys;
            n_b_beat.z = r_a_fld.fy[FW-1] ? -chf_pkg::Z_180 : chf_pkg::Z_180;
        end else begin
            n_b_beat.x = xs;
            n_b_beat.y = ys;
            n_b_beat.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b && r_a_valid) begin
            r_b_beat <= n_b_beat;
        end
    end

    assign o_beat  = r_b_beat;
    assign o_valid = r_b_valid;

    `CHF_ASSERT_NXT(a_front_hold, r_a_valid && !en_b, r_a_valid && $stable(r_a_fld),
        "front stage lost or changed a stalled beat")
    `CHF_ASSERT_IMP(a_axis_bypass,
        r_b_valid && (r_b_beat.fld.fx == '0 || r_b_beat.fld.fy == '0), r_b_beat.bypass,
        "vector on an axis did not take the exact path")

endmodule

// ===== hdl/chf_stage.sv =====
`include "compass_heading_from_field_top_assert.svh"

module chf_stage #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  chf_pkg::t_cord i_beat,
    input  logic           i_valid,
    output logic           o_ready,
    output chf_pkg::t_cord o_beat,
    output logic           o_valid,
    input  logic           i_ready
);

    localparam logic [chf_pkg::ATAN_IDX_W-1:0] KI = chf_pkg::ATAN_IDX_W'(STEP % 32);

    logic                         r_valid;
    chf_pkg::t_cord               r_beat;
    chf_pkg::t_cord               n_beat;
    logic                         en;
    logic signed [chf_pkg::CW-1:0] x_sh;
    logic signed [chf_pkg::CW-1:0] y_sh;
    logic signed [chf_pkg::ZW-1:0] ang;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    always_comb begin
        x_sh   = i_beat.x >>> KI;
        y_sh   = i_beat.y >>> KI;
        ang    = chf_pkg::atan_q16(KI);
        n_beat = i_beat;
        if (!i_beat.y[chf_pkg::CW-1]) begin
            n_beat.x = i_beat.x + y_sh;
            n_beat.y = i_beat.y - x_sh;
            n_beat.z = i_beat.z + ang;
        end else begin
            n_beat.x = i_beat.x - y_sh;
            n_beat.y = i_beat.y + x_sh;
            n_beat.z = i_beat.z - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat  = r_beat;
    assign o_valid = r_valid;

    `CHF_ASSERT_NXT(a_stage_hold, r_valid && !i_ready, r_valid && $stable(r_beat),
        "rotation stage lost or changed a stalled beat")

endmodule

// ===== hdl/chf_back.sv =====
`include "compass_heading_from_field_top_assert.svh"

module chf_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  chf_pkg::t_cord                    i_beat,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [chf_pkg::DEG_W-1:0]  i_decl,
    chf_out_if.source                         o_out
);

    localparam int ZW    = chf_pkg::ZW;
    localparam int ZT_W  = chf_pkg::ZT_W;
    localparam int SUM_W = chf_pkg::SUM_W;
    localparam int FW    = chf_pkg::FLD_W;
    localparam int DW    = chf_pkg::DEG_W;

    logic                    r_valid;
    logic signed [FW-1:0]    r_fx;
    logic signed [FW-1:0]    r_fy;
    logic signed [FW-1:0]    r_fz;
    logic        [DW-1:0]    r_head;
    logic                    r_ok;
    logic                    en;
    logic signed [ZW-1:0]    z_neg;
    logic signed [ZW-1:0]    z_sh;
    logic signed [ZT_W-1:0]  z_int;
    logic signed [SUM_W-1:0] deg;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] wrapped;

    assign en      = !r_valid || o_out.ready;
    assign o_ready = en;

    always_comb begin
        // Truncate the Q16 angle toward zero.
        z_neg = -i_beat.z;
        z_sh  = z_neg >>> chf_pkg::ZFRAC;
        if (!i_beat.z[ZW-1]) begin
            z_int = ZT_W'(i_beat.z >>> chf_pkg::ZFRAC);
        end else begin
            z_int = -ZT_W'(z_sh);
        end
        if (i_beat.bypass) begin
            deg = {{(SUM_W-DW){i_beat.byp_deg[DW-1]}}, i_beat.byp_deg};
        end else begin
            deg = {z_int[ZT_W-1], z_int};
        end
        sum = deg + {{(SUM_W-DW){i_decl[DW-1]}}, i_decl};
        if (sum < chf_pkg::SUM_N360) begin
            wrapped = sum + chf_pkg::SUM_720;
        end else if (sum < 0) begin
            wrapped = sum + chf_pkg::SUM_360;
        end else if (sum > chf_pkg::SUM_360) begin
            wrapped = sum - chf_pkg::SUM_360;
        end else begin
            wrapped = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_ok   <= i_beat.fld.ok;
            r_fx   <= i_beat.fld.ok ? i_beat.fld.fx : '0;
            r_fy   <= i_beat.fld.ok ? i_beat.fld.fy : '0;
            r_fz   <= i_beat.fld.ok ? i_beat.fld.fz : '0;
            r_head <= i_beat.fld.ok ? wrapped[DW-1:0] : '0;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.field_x     = r_fx;
    assign o_out.field_y     = r_fy;
    assign o_out.field_z     = r_fz;
    assign o_out.heading_deg = r_head;
    assign o_out.ok          = r_ok;

    `CHF_ASSERT_IMP(a_head_range, r_valid, r_head <= DW'(360),
        "heading left the range up to 360")
    `CHF_ASSERT_IMP(a_bad_zero, r_valid && !r_ok,
        r_fx == '0 && r_fy == '0 && r_fz == '0 && r_head == '0,
        "failed reading produced nonzero fields")

endmodule
